>>> rtl/core/ssbs_pkg.sv
`timescale 1ns / 1ps

package ssbs_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int LEN_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int RND_W     = $clog2(LEN_W + 1);

  localparam logic [OP_W-1:0] OP_WR_SEQ = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_SRT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SORTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOAT_CMP  = 2'd3;

  localparam logic [LEN_W-1:0] SEQ_LEN_RESET = 11'd1;

  typedef struct packed {
    logic [LEN_W-1:0] seq_len;
    logic             right_side;
    logic             use_sorter;
    logic             float_compare;
  } cfg_t;

  function automatic logic f_nan(input logic [31:0] v);
    f_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Maps an IEEE single onto unsigned order, both zeros to one key.
  function automatic logic [31:0] f_key(input logic [31:0] v);
    logic [31:0] k;
    if (v[30:0] == 31'd0) begin
      k = 32'h8000_0000;
    end else if (v[31]) begin
      k = ~v;
    end else begin
      k = v | 32'h8000_0000;
    end
    f_key = k;
  endfunction

  // Number of significant bits, i.e. the round count of the search.
  function automatic logic [RND_W-1:0] bit_len(input logic [LEN_W-1:0] v);
    logic [RND_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (v[i]) begin
        r = RND_W'(i + 1);
      end
    end
    bit_len = r;
  endfunction

endpackage

>>> rtl/core/ssbs_in_if.sv
`timescale 1ns / 1ps

interface ssbs_in_if;
  import ssbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  entry_index;
  logic [DATA_W-1:0] data_value;

  modport source (output valid, output opcode, output entry_index, output data_value,
                  input ready);
  modport sink (input valid, input opcode, input entry_index, input data_value,
                output ready);
endinterface

>>> rtl/core/ssbs_out_if.sv
`timescale 1ns / 1ps

interface ssbs_out_if;
  import ssbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

>>> rtl/core/ssbs_ram.sv
`timescale 1ns / 1ps

module ssbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ssbs_cmp.sv
`timescale 1ns / 1ps

module ssbs_cmp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic [VALUE_WIDTH-1:0] elem,
  input  logic [VALUE_WIDTH-1:0] query,
  input  logic                   float_mode,
  input  logic                   right_side,
  output logic                   goes_left
);
  import ssbs_pkg::*;

  logic [VALUE_WIDTH-1:0] ik_a, ik_b;
  logic [31:0]            fa, fb, fk_a, fk_b;
  logic                   int_lt, int_eq, flt_lt, flt_eq, any_nan;

  always_comb begin
    // flip the sign bit so signed order becomes unsigned order
    ik_a    = elem  ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH - 1));
    ik_b    = query ^ (VALUE_WIDTH'(1) << (VALUE_WIDTH - 1));
    int_lt  = ik_a < ik_b;
    int_eq  = ik_a == ik_b;
    fa      = 32'(elem);
    fb      = 32'(query);
    fk_a    = f_key(fa);
    fk_b    = f_key(fb);
    flt_lt  = fk_a < fk_b;
    flt_eq  = fk_a == fk_b;
    any_nan = f_nan(fa) || f_nan(fb);
    if (float_mode) begin
      goes_left = !any_nan && (flt_lt || (right_side && flt_eq));
    end else begin
      goes_left = int_lt || (right_side && int_eq);
    end
  end

endmodule

>>> rtl/core/ssbs_ctrl.sv
`timescale 1ns / 1ps

module ssbs_ctrl #(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssbs_pkg::cfg_t                   cfg,
  input  logic                             start,
  input  logic [ssbs_pkg::DATA_W-1:0]      query,
  output logic                             idle,
  output logic                             srt_re,
  output logic [$clog2(MAX_LEN)-1:0]       srt_raddr,
  input  logic [$clog2(MAX_LEN)-1:0]       srt_q,
  output logic                             seq_re,
  output logic [$clog2(MAX_LEN)-1:0]       seq_raddr,
  input  logic [VALUE_WIDTH-1:0]           seq_q,
  input  logic                             out_free,
  output logic                             res_load,
  output logic [ssbs_pkg::LEN_W-1:0]       res_pos
);
  import ssbs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = (AW > LEN_W) ? AW : LEN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_SORT = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [LEN_W-1:0]       low_r, low_nxt, high_r, high_nxt, mid_r, mid_nxt, n_r, n_nxt;
  logic [RND_W-1:0]       round_r, round_nxt;
  logic [VALUE_WIDTH-1:0] query_r, query_nxt;

  logic [LEN_W-1:0] n_w, nm1, mid_w, at_w;
  logic [LEN_W:0]   up_w;
  logic [AW-1:0]    srt_idx;
  logic [RND_W-1:0] rounds_w;
  logic             left;

  ssbs_cmp #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmp (
    .elem       (seq_q),
    .query      (query_r),
    .float_mode (cfg.float_compare),
    .right_side (cfg.right_side),
    .goes_left  (left)
  );

  always_comb begin
    n_w      = (32'(cfg.seq_len) > MAX_LEN) ? LEN_W'(MAX_LEN) : cfg.seq_len;
    rounds_w = bit_len(n_w);
    nm1      = n_r - LEN_W'(1);
    mid_w    = low_r + ((high_r - low_r) >> 1);
    at_w     = (mid_w > nm1) ? nm1 : mid_w;
    srt_idx  = (CW'(srt_q) > CW'(nm1)) ? AW'(nm1) : srt_q;
    up_w     = {1'b0, mid_r} + (LEN_W + 1)'(1);
  end

  assign idle      = (state_r == ST_IDLE);
  assign srt_re    = (state_r == ST_ADDR) && cfg.use_sorter;
  assign srt_raddr = AW'(at_w);
  assign seq_re    = ((state_r == ST_ADDR) && !cfg.use_sorter) || (state_r == ST_SORT);
  assign seq_raddr = (state_r == ST_SORT) ? srt_idx : AW'(at_w);
  assign res_load  = (state_r == ST_DONE) && out_free;
  // a NaN query lands past the end whatever the rounds found
  assign res_pos   = (cfg.float_compare && f_nan(32'(query_r))) ? n_r : low_r;

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    mid_nxt   = mid_r;
    n_nxt     = n_r;
    round_nxt = round_r;
    query_nxt = query_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          low_nxt   = '0;
          high_nxt  = n_w;
          n_nxt     = n_w;
          round_nxt = rounds_w;
          query_nxt = VALUE_WIDTH'(query);
          state_nxt = (rounds_w == '0) ? ST_DONE : ST_ADDR;
        end
      end
      ST_ADDR: begin
        mid_nxt   = mid_w;
        state_nxt = cfg.use_sorter ? ST_SORT : ST_CMP;
      end
      ST_SORT: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (left) begin
          low_nxt = (up_w > {1'b0, n_r}) ? n_r : up_w[LEN_W-1:0];
        end else begin
          high_nxt = mid_r;
        end
        round_nxt = round_r - RND_W'(1);
        state_nxt = (round_r == RND_W'(1)) ? ST_DONE : ST_ADDR;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    mid_r   <= mid_nxt;
    n_r     <= n_nxt;
    query_r <= query_nxt;
  end

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (low_r <= high_r))
    else $error("search bounds crossed");

  a_high_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (high_r <= n_r))
    else $error("upper bound beyond sequence length");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_ADDR || $past(state_r) == ST_SORT))
    else $error("compare without a preceding read");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (idle && start) |=> (state_r == ST_ADDR || state_r == ST_DONE))
    else $error("query not started");

endmodule

>>> rtl/core/sorted_sequence_bound_search_unit.sv
`timescale 1ns / 1ps

// Bound search over a sorted sequence held in on-chip memory. Beats with opcode 0 or 1
// write one sequence or sorter entry and give no result, opcode 3 beats are taken and
// dropped, and a query beat (opcode 2) gives one position beat. A query of length N
// takes R rounds, R being the bit length of N: each round is a registered read of the
// sequence memory, preceded by a read of the sorter memory when indirection is on, then
// one compare and bound update. The input is not ready while a query is in flight; a
// finished position sits in an output register, and the next beat is taken as soon as
// the search has handed its result over.
module sorted_sequence_bound_search_unit #(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ssbs_in_if.sink                            in_bus,
  ssbs_out_if.source                         out_bus,
  input  logic                               cfg_we,
  input  logic [ssbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssbs_pkg::CFG_W-1:0]         cfg_data
);
  import ssbs_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  cfg_t             cfg_r;
  logic             out_valid_r;
  logic [LEN_W-1:0] out_pos_r;

  logic                   in_fire, idx_ok, idle, start, out_free, res_load;
  logic                   seq_we, srt_we, srt_re, seq_re;
  logic [AW-1:0]          waddr, srt_wdata, srt_raddr, seq_raddr, srt_q;
  logic [VALUE_WIDTH-1:0] seq_q;
  logic [LEN_W-1:0]       res_pos;

  assign in_bus.ready = idle;
  assign in_fire      = in_bus.valid && idle;
  assign idx_ok       = 32'(in_bus.entry_index) < MAX_LEN;
  assign waddr        = AW'(in_bus.entry_index);
  assign seq_we       = in_fire && (in_bus.opcode == OP_WR_SEQ) && idx_ok;
  assign srt_we       = in_fire && (in_bus.opcode == OP_WR_SRT) && idx_ok;
  assign start        = in_fire && (in_bus.opcode == OP_QUERY);
  // sorter entries saturate to the last store position on write
  assign srt_wdata    = (in_bus.data_value > 32'(MAX_LEN - 1)) ? AW'(MAX_LEN - 1)
                                                                : AW'(in_bus.data_value);
  assign out_free     = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seq_len       <= SEQ_LEN_RESET;
      cfg_r.right_side    <= 1'b0;
      cfg_r.use_sorter    <= 1'b0;
      cfg_r.float_compare <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEQ_LEN:    cfg_r.seq_len       <= cfg_data[LEN_W-1:0];
        REG_RIGHT_SIDE: cfg_r.right_side    <= cfg_data[0];
        REG_USE_SORTER: cfg_r.use_sorter    <= cfg_data[0];
        REG_FLOAT_CMP:  cfg_r.float_compare <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ssbs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_LEN)) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (waddr),
    .wdata (VALUE_WIDTH'(in_bus.data_value)),
    .re    (seq_re),
    .raddr (seq_raddr),
    .rdata (seq_q)
  );

  ssbs_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (waddr),
    .wdata (srt_wdata),
    .re    (srt_re),
    .raddr (srt_raddr),
    .rdata (srt_q)
  );

  ssbs_ctrl #(.MAX_LEN(MAX_LEN), .VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (start),
    .query     (in_bus.data_value),
    .idle      (idle),
    .srt_re    (srt_re),
    .srt_raddr (srt_raddr),
    .srt_q     (srt_q),
    .seq_re    (seq_re),
    .seq_raddr (seq_raddr),
    .seq_q     (seq_q),
    .out_free  (out_free),
    .res_load  (res_load),
    .res_pos   (res_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pos_r <= res_pos;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.position = out_pos_r;

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_bus.ready))
    else $error("result overwrote an untaken beat");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_we || srt_we) |-> idle)
    else $error("store written during a search");

  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && out_free) |=> !idle)
    else $error("query accepted but search not running");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssbs_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int RANDOM_ITEMS  = 400;
  localparam int REST_CYCLES   = 48;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int PLAN_ROWS     = 32;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic signed [11:0] PREDICTED = -12'sd1;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         code;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  data;
    logic signed [11:0] want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ssbs_in_if  in_ch ();
  ssbs_out_if out_ch ();

  sorted_sequence_bound_search_unit #(
    .MAX_LEN    (DEPTH),
    .VALUE_WIDTH(DATA_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copies of the stores and registers
  logic [DATA_W-1:0] seq_mem [DEPTH];
  logic [IDX_W-1:0]  srt_mem [DEPTH];
  cfg_t              regs_now;

  logic [LEN_W-1:0]  positions_due [$];
  logic [DATA_W-1:0] vals [DEPTH];   // sequence in search order, for picking queries
  bit                deep_loaded [DEPTH];
  row_t              plan [PLAN_ROWS];

  int errors;
  int queries_sent;
  int writes_sent;
  int settings_used;
  int hold_req;
  int tx_gap_pct;
  int rx_stall_pct;
  int quiet_cycles;

  function automatic bit is_nan_single(input logic [31:0] v);
    return (&v[30:23]) && (|v[22:0]);
  endfunction

  // unsigned ordering of singles; both zeros share one key
  function automatic logic [31:0] single_order_key(input logic [31:0] v);
    if (v[30:0] == 31'd0) return 32'h8000_0000;
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  function automatic logic [31:0] raw_from_key(input logic [31:0] k, input bit as_float);
    if (!as_float) return k ^ 32'h8000_0000;
    if (k[31]) return {1'b0, k[30:0]};
    return ~k;
  endfunction

  function automatic bit lies_left(input logic [31:0] elem, input logic [31:0] q);
    logic [31:0] ke, kq;
    if (regs_now.float_compare) begin
      if (is_nan_single(elem) || is_nan_single(q)) return 1'b0;
      ke = single_order_key(elem);
      kq = single_order_key(q);
      return regs_now.right_side ? (ke <= kq) : (ke < kq);
    end
    return regs_now.right_side ? ($signed(elem) <= $signed(q)) : ($signed(elem) < $signed(q));
  endfunction

  function automatic logic [LEN_W-1:0] bound_position(input logic [31:0] q);
    int n, lo, hi, mid, at, rounds, t;
    logic [IDX_W-1:0] slot;
    n = (regs_now.seq_len > LEN_W'(DEPTH)) ? DEPTH : int'(regs_now.seq_len);
    rounds = 0;
    t = n;
    while (t > 0) begin
      rounds++;
      t = t / 2;
    end
    lo = 0;
    hi = n;
    for (int r = 0; r < rounds; r++) begin
      mid = lo + (hi - lo) / 2;
      at = (mid < n - 1) ? mid : n - 1;
      slot = IDX_W'(at);
      if (regs_now.use_sorter) begin
        slot = srt_mem[at];
        if (int'(slot) > n - 1) slot = IDX_W'(n - 1);
      end
      if (lies_left(seq_mem[slot], q)) begin
        lo = (mid + 1 < n) ? mid + 1 : n;
      end else begin
        hi = mid;
      end
    end
    if (regs_now.float_compare && is_nan_single(q)) return LEN_W'(n);
    return LEN_W'(lo);
  endfunction

  task automatic report_mismatch(input string what, input logic [LEN_W-1:0] got,
                                 input logic [LEN_W-1:0] want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t: %s: position %0d, wanted %0d", $time, what, got, want);
    end
  endtask

  task automatic idle_for(input int k);
    in_ch.valid <= 1'b0;
    repeat (k) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      idle_for($urandom_range(1, 5));
    end
  endtask

  // offer one beat and hold it until taken; the shadow state follows at the accepting edge
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] slot,
                           input logic [DATA_W-1:0] value, input int want);
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.entry_index <= slot;
    in_ch.data_value  <= value;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_WR_SEQ: begin
        seq_mem[slot] = value;
        writes_sent++;
      end
      OP_WR_SRT: begin
        srt_mem[slot] = (value > DEPTH - 1) ? IDX_W'(DEPTH - 1) : value[IDX_W-1:0];
        writes_sent++;
      end
      OP_QUERY: begin
        positions_due.insert(positions_due.size(),
                             (want >= 0) ? LEN_W'(want) : bound_position(value));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_all_back();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (positions_due.size() != 0);
  endtask

  task automatic drain_and_rest();
    wait_all_back();
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] code, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= code;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (code)
      REG_SEQ_LEN:    regs_now.seq_len       = value[LEN_W-1:0];
      REG_RIGHT_SIDE: regs_now.right_side    = value[0];
      REG_USE_SORTER: regs_now.use_sorter    = value[0];
      REG_FLOAT_CMP:  regs_now.float_compare = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one-bit registers get junk in the upper bits
  task automatic apply_settings(input int len, input bit right, input bit sorter, input bit flt);
    logic [CFG_W-1:0] junk;
    drain_and_rest();
    junk = CFG_W'($urandom);
    set_reg(REG_SEQ_LEN, CFG_W'(len));
    set_reg(REG_RIGHT_SIDE, {junk[CFG_W-1:1], right});
    set_reg(REG_USE_SORTER, {junk[CFG_W-2:0], sorter});
    set_reg(REG_FLOAT_CMP, {junk[CFG_W-1:1], flt});
    settings_used++;
  endtask

  // Loads entries 0..n-1. Mostly an ascending run, sometimes scattered through the
  // sequence store so that the indirect read through the sorter store sees it sorted.
  task automatic fill_stores(input int n, input bit via_sorter, input bit as_float);
    int perm [DEPTH];
    int j, tmp;
    longint unsigned span, room, key;
    logic [DATA_W-1:0] srt_val;
    bit ordered;
    if (n == 0) return;
    ordered = ($urandom_range(0, 99) < 85);
    span = ($urandom_range(0, 3) == 0) ? 64'd3 : 64'hFFFF_FFFF / n;
    room = 64'h1_0000_0000 - span * n;
    key = $urandom % room;
    for (int i = 0; i < n; i++) begin
      vals[i] = ordered ? raw_from_key(32'(key), as_float) : $urandom;
      if ($urandom_range(0, 3) != 0) key += $urandom % (span + 1);
    end
    if (ordered && $urandom_range(0, 4) == 0) begin
      vals[0]   = raw_from_key(32'h0000_0000, as_float);
      vals[n-1] = raw_from_key(32'hFFFF_FFFF, as_float);
    end
    for (int i = 0; i < n; i++) perm[i] = i;
    if (via_sorter) begin
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
    end
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      send_beat(OP_WR_SEQ, IDX_W'(perm[i]), vals[i], PREDICTED);
    end
    if (via_sorter) begin
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0:       srt_val = $urandom;
          1:       srt_val = $urandom_range(0, DEPTH - 1);
          default: srt_val = perm[i];
        endcase
        maybe_gap();
        send_beat(OP_WR_SRT, IDX_W'(i), srt_val, PREDICTED);
      end
    end
  endtask

  // Full-depth searches without loading the whole store: before each query only the
  // entries that its search visits are written, taken from an ascending signed run.
  task automatic deep_queries(input int count, input bit fresh);
    logic [DATA_W-1:0] q;
    longint unsigned key;
    int lo, hi, mid, at;
    if (fresh) begin
      key = $urandom_range(0, 1023);
      for (int i = 0; i < DEPTH; i++) begin
        vals[i] = raw_from_key(32'(key), 1'b0);
        deep_loaded[i] = 1'b0;
        key += $urandom_range(0, 4000000);
      end
    end
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 5))
        0:       q = 32'h8000_0000;
        1:       q = 32'h7FFF_FFFF;
        2:       q = vals[$urandom_range(0, DEPTH - 1)] + 32'd1;
        default: q = vals[$urandom_range(0, DEPTH - 1)];
      endcase
      lo = 0;
      hi = DEPTH;
      for (int r = 0; r <= $clog2(DEPTH); r++) begin
        mid = lo + (hi - lo) / 2;
        at = (mid < DEPTH - 1) ? mid : DEPTH - 1;
        if (!deep_loaded[at]) begin
          maybe_gap();
          send_beat(OP_WR_SEQ, IDX_W'(at), vals[at], PREDICTED);
          deep_loaded[at] = 1'b1;
        end
        if (lies_left(vals[at], q)) begin
          lo = (mid + 1 < DEPTH) ? mid + 1 : DEPTH;
        end else begin
          hi = mid;
        end
      end
      maybe_gap();
      send_beat(OP_QUERY, IDX_W'($urandom), q, PREDICTED);
    end
  endtask

  task automatic run_queries(input int n, input int count);
    logic [DATA_W-1:0] q;
    logic [OP_W-1:0] op;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        maybe_gap();
        send_beat(OP_UNUSED, IDX_W'($urandom), $urandom, PREDICTED);
      end
      // stray write that may break the ordering
      if ($urandom_range(0, 19) == 0) begin
        op = $urandom_range(0, 1) ? OP_WR_SEQ : OP_WR_SRT;
        maybe_gap();
        send_beat(op, IDX_W'($urandom), $urandom, PREDICTED);
      end
      if ($urandom_range(0, 11) == 0) wait_all_back();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: q = (n > 0) ? vals[$urandom_range(0, n - 1)] : $urandom;
        4, 5: begin
          q = (n > 0) ? vals[$urandom_range(0, n - 1)] : $urandom;
          q = $urandom_range(0, 1) ? q + 32'd1 : q - 32'd1;
        end
        6: begin
          case ($urandom_range(0, 7))
            0:       q = 32'h0000_0000;
            1:       q = 32'h8000_0000;
            2:       q = 32'h7FFF_FFFF;
            3:       q = 32'hFFFF_FFFF;
            4:       q = 32'h7F80_0000;
            5:       q = 32'hFF80_0000;
            6:       q = 32'h7FC0_0000;
            default: q = 32'h3F80_0000;
          endcase
        end
        default: q = $urandom;
      endcase
      maybe_gap();
      send_beat(OP_QUERY, IDX_W'($urandom), q, PREDICTED);
    end
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0:       tx_gap_pct = 0;
      1:       tx_gap_pct = 20;
      default: tx_gap_pct = 50;
    endcase
    case ($urandom_range(0, 2))
      0:       rx_stall_pct = 0;
      1:       rx_stall_pct = 20;
      default: rx_stall_pct = 50;
    endcase
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_positions
    logic [LEN_W-1:0] due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (positions_due.size() == 0) begin
        report_mismatch("position beat with no query pending", out_ch.position, '0);
      end else begin
        due = positions_due.pop_front();
        if (out_ch.position !== due) begin
          report_mismatch("wrong position", out_ch.position, due);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d positions outstanding", QUIET_LIMIT,
                 positions_due.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int ph, len, random_items;
    bit flt, sorter;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.entry_index = '0;
    in_ch.data_value  = '0;
    regs_now = '{seq_len: SEQ_LEN_RESET, right_side: 1'b0, use_sorter: 1'b0,
                 float_compare: 1'b0};
    errors = 0;
    queries_sent = 0;
    writes_sent = 0;
    settings_used = 1;
    hold_req = 0;
    quiet_cycles = 0;
    tx_gap_pct = 30;
    rx_stall_pct = 30;

    // expected positions typed in where obvious, otherwise predicted
    plan = '{
      '{ROW_BEAT, OP_WR_SEQ,      10'h000, 32'h0000_0005, PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h0000_0005, 12'sd0},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h0000_0006, 12'sd1},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h7FFF_FFFF, 12'sd1},
      '{ROW_REG,  REG_SEQ_LEN,    10'h000, 32'd0,         PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'hFFFF_FFFF, 12'sd0},
      '{ROW_REG,  REG_SEQ_LEN,    10'h000, 32'd4,         PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h000, 32'h8000_0000, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h001, 32'hFFFF_FFFF, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h002, 32'h0000_0005, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h003, 32'h7FFF_FFFF, PREDICTED},
      '{ROW_BEAT, OP_UNUSED,      10'h3FF, 32'hFFFF_FFFF, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h3FF, 32'hAAAA_5555, PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h8000_0000, 12'sd0},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h7FFF_FFFF, 12'sd3},
      '{ROW_REG,  REG_RIGHT_SIDE, 10'h000, 32'd1,         PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h7FFF_FFFF, 12'sd4},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h0000_0005, 12'sd3},
      '{ROW_REG,  REG_USE_SORTER, 10'h000, 32'd1,         PREDICTED},
      '{ROW_BEAT, OP_WR_SRT,      10'h000, 32'hFFFF_FFFF, PREDICTED},
      '{ROW_BEAT, OP_WR_SRT,      10'h001, 32'd2,         PREDICTED},
      '{ROW_BEAT, OP_WR_SRT,      10'h002, 32'd1,         PREDICTED},
      '{ROW_BEAT, OP_WR_SRT,      10'h003, 32'd0,         PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h0000_0005, PREDICTED},
      '{ROW_REG,  REG_USE_SORTER, 10'h000, 32'd0,         PREDICTED},
      '{ROW_REG,  REG_FLOAT_CMP,  10'h000, 32'd1,         PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h000, 32'hFF80_0000, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h001, 32'h8000_0000, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h002, 32'h3F80_0000, PREDICTED},
      '{ROW_BEAT, OP_WR_SEQ,      10'h003, 32'h7F80_0000, PREDICTED},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h0000_0000, 12'sd2},
      '{ROW_BEAT, OP_QUERY,       10'h000, 32'h7FC0_0000, 12'sd4}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        drain_and_rest();
        set_reg(plan[r].code, plan[r].data[CFG_W-1:0]);
      end else begin
        maybe_gap();
        send_beat(plan[r].code, plan[r].idx, plan[r].data, int'(plan[r].want));
      end
    end

    ph = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      ph++;
      if (random_items >= RANDOM_ITEMS - 60) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        pick_idling();
      end
      if (ph == 2) begin
        // full-depth store, then a length above the store size
        apply_settings(DEPTH, 1'b0, 1'b0, 1'b0);
        deep_queries(12, 1'b1);
        apply_settings(2047, 1'b1, 1'b0, 1'b0);
        deep_queries(12, 1'b0);
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:5]:   len = 0;
          [6:59]:  len = $urandom_range(1, 8);
          [60:84]: len = $urandom_range(9, 40);
          default: len = $urandom_range(41, 300);
        endcase
        // keep the load within what is left of the item budget
        if (len > (RANDOM_ITEMS - random_items) / 4) len = (RANDOM_ITEMS - random_items) / 4;
        sorter = ($urandom_range(0, 9) < 4);
        flt = $urandom_range(0, 1);
        apply_settings(len, $urandom_range(0, 1), sorter, flt);
        fill_stores(len, sorter, flt);
        if (ph == 1) begin
          // receiver goes quiet while queries keep coming
          hold_req = HOLD_CYCLES;
        end
        run_queries(len, $urandom_range(4, 14));
      end
      random_items = queries_sent + writes_sent;
    end

    in_ch.valid <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);

    $display("run covered %0d queries and %0d store writes over %0d register settings",
             queries_sent, writes_sent, settings_used);
    $display("lengths 0 to 2047, both bound sides, sorter indirection, signed and float order;"
             , " %0d mismatches", errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ssbs_pkg.sv
rtl/core/ssbs_in_if.sv
rtl/core/ssbs_out_if.sv
rtl/core/ssbs_ram.sv
rtl/core/ssbs_cmp.sv
rtl/core/ssbs_ctrl.sv
rtl/core/sorted_sequence_bound_search_unit.sv
bench/testbench.sv
